[rtl/core/ssc_pkg.sv]
package ssc_pkg;

    localparam logic [3:0] SIGN_NONE    = 4'd0;
    localparam logic [3:0] SIGN_END     = 4'd1;
    localparam logic [3:0] SIGN_INVALID = 4'd15;

    localparam logic [15:0] CONFIRM_MIN_RST = 16'd200;
    localparam logic [15:0] CONFIRM_MAX_RST = 16'd10000;
    localparam logic [15:0] CLEAR_MIN_RST   = 16'd1000;
    localparam logic [15:0] CLEAR_MAX_RST   = 16'd10000;

    typedef enum logic [1:0] {
        CFG_CONFIRM_MIN = 2'd0,
        CFG_CONFIRM_MAX = 2'd1,
        CFG_CLEAR_MIN   = 2'd2,
        CFG_CLEAR_MAX   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] confirm_min;
        logic [15:0] confirm_max;
        logic [15:0] clear_min;
        logic [15:0] clear_max;
    } cfg_t;

    // One detected object after the area stage (area travels beside it).
    typedef struct packed {
        logic [3:0]  code;
        logic [31:0] now;
        logic        last;
    } item_t;

    function automatic logic [6:0] kmh_of(input logic [3:0] code);
        logic [6:0] kmh;
        case (code)
            4'd2:    kmh = 7'd5;
            4'd3:    kmh = 7'd10;
            4'd4:    kmh = 7'd20;
            4'd5:    kmh = 7'd30;
            4'd6:    kmh = 7'd40;
            4'd7:    kmh = 7'd50;
            4'd8:    kmh = 7'd60;
            4'd9:    kmh = 7'd70;
            4'd10:   kmh = 7'd80;
            4'd11:   kmh = 7'd90;
            4'd12:   kmh = 7'd100;
            4'd13:   kmh = 7'd110;
            4'd14:   kmh = 7'd120;
            default: kmh = 7'd0;
        endcase
        return kmh;
    endfunction

endpackage

[rtl/core/ssc_area_stage.sv]
module ssc_area_stage
    import ssc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [3:0]              s_sign_code,
    input  logic [COORD_BITS-1:0]   s_box_x1,
    input  logic [COORD_BITS-1:0]   s_box_y1,
    input  logic [COORD_BITS-1:0]   s_box_x2,
    input  logic [COORD_BITS-1:0]   s_box_y2,
    input  logic [31:0]             s_now_ms,
    input  logic                    s_frame_end,
    input  logic                    take,
    output logic                    a_valid,
    output item_t                   a_item,
    output logic [2*COORD_BITS-1:0] a_area
);

    logic                    valid_reg, valid_next;
    item_t                   item_reg;
    logic [2*COORD_BITS-1:0] area_reg;
    logic [COORD_BITS-1:0]   dx, dy;
    logic                    counts;
    logic [2*COORD_BITS-1:0] area_next;
    logic                    load;

    assign s_ready = !valid_reg || take;
    assign load    = s_valid && s_ready;

    // Code 15 means nothing; empty or inverted boxes weigh zero.
    assign counts = (s_sign_code != SIGN_NONE) && (s_sign_code != SIGN_INVALID) &&
                    (s_box_x2 > s_box_x1) && (s_box_y2 > s_box_y1);
    assign dx = s_box_x2 - s_box_x1;
    assign dy = s_box_y2 - s_box_y1;
    assign area_next = counts ? ({{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dy}) : '0;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.code <= (s_sign_code == SIGN_INVALID) ? SIGN_NONE : s_sign_code;
            item_reg.now  <= s_now_ms;
            item_reg.last <= s_frame_end;
            area_reg      <= area_next;
        end
    end

    assign a_valid = valid_reg;
    assign a_item  = item_reg;
    assign a_area  = area_reg;

endmodule

[rtl/core/ssc_presence.sv]
module ssc_presence
    import ssc_pkg::*;
#(
    parameter int AREA_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 a_valid,
    input  item_t                a_item,
    input  logic [AREA_BITS-1:0] a_area,
    input  cfg_t                 cfg,
    output logic                 take,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_limit_event,
    output logic [6:0]           m_limit_kmh,
    output logic                 m_remove_event,
    output logic                 m_sign_present,
    output logic [3:0]           m_held_sign
);

    logic [AREA_BITS-1:0] best_area_reg, best_area_next;
    logic [3:0]           best_sign_reg, best_sign_next;
    logic                 present_reg, present_next;
    logic [3:0]           held_reg, held_next;
    logic [31:0]          seen_reg, seen_next;
    logic [31:0]          lost_reg, lost_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 lim_ev_reg, rem_ev_reg;
    logic [6:0]           kmh_reg;
    logic                 present_out_reg;
    logic [3:0]           held_out_reg;

    logic                 out_free;
    logic                 larger;
    logic [3:0]           frame_sign;
    logic [31:0]          dt_seen, dt_lost;
    logic                 lim_ev, rem_ev;
    logic                 frame_done;

    assign out_free   = !m_valid_reg || m_ready;
    assign take       = a_valid && (!a_item.last || out_free);
    assign frame_done = take && a_item.last;

    assign larger     = a_area > best_area_reg;
    assign frame_sign = larger ? a_item.code : best_sign_reg;
    assign dt_seen    = a_item.now - seen_reg;
    assign dt_lost    = a_item.now - lost_reg;

    always_comb begin
        present_next = present_reg;
        held_next    = held_reg;
        seen_next    = seen_reg;
        lost_next    = lost_reg;
        lim_ev       = 1'b0;
        rem_ev       = 1'b0;
        if (present_reg && frame_sign == SIGN_NONE) begin
            lost_next    = a_item.now;
            present_next = 1'b0;
        end else if (!present_reg && frame_sign != SIGN_NONE) begin
            seen_next    = a_item.now;
            held_next    = frame_sign;
            present_next = 1'b1;
        end else if (present_reg) begin
            if (frame_sign != held_reg) begin
                seen_next = a_item.now;
                held_next = frame_sign;
            end else if (dt_seen > {16'd0, cfg.confirm_min} &&
                         dt_seen < {16'd0, cfg.confirm_max}) begin
                if (frame_sign == SIGN_END) begin
                    rem_ev = 1'b1;
                end else begin
                    lim_ev = 1'b1;
                end
            end
        end else begin
            if (dt_lost > {16'd0, cfg.clear_min} && dt_lost < {16'd0, cfg.clear_max}) begin
                held_next = SIGN_NONE;
            end
        end
    end

    always_comb begin
        best_area_next = best_area_reg;
        best_sign_next = best_sign_reg;
        if (frame_done) begin
            best_area_next = '0;
            best_sign_next = SIGN_NONE;
        end else if (take && larger) begin
            best_area_next = a_area;
            best_sign_next = a_item.code;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (frame_done) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_area_reg <= '0;
            best_sign_reg <= SIGN_NONE;
            present_reg   <= 1'b0;
            held_reg      <= SIGN_NONE;
            seen_reg      <= '0;
            lost_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            best_area_reg <= best_area_next;
            best_sign_reg <= best_sign_next;
            m_valid_reg   <= m_valid_next;
            if (frame_done) begin
                present_reg <= present_next;
                held_reg    <= held_next;
                seen_reg    <= seen_next;
                lost_reg    <= lost_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            lim_ev_reg      <= lim_ev;
            rem_ev_reg      <= rem_ev;
            kmh_reg         <= lim_ev ? kmh_of(frame_sign) : 7'd0;
            present_out_reg <= present_next;
            held_out_reg    <= held_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_limit_event  = lim_ev_reg;
    assign m_limit_kmh    = kmh_reg;
    assign m_remove_event = rem_ev_reg;
    assign m_sign_present = present_out_reg;
    assign m_held_sign    = held_out_reg;

`ifndef SYNTHESIS
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_limit_event && m_remove_event))
        else $error("limit and remove events in one beat");

    a_kmh_matches_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_limit_kmh != 7'd0) == m_limit_event))
        else $error("limit_kmh disagrees with limit_event");

    a_event_needs_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_limit_event || m_remove_event) |->
            m_sign_present && m_held_sign != SIGN_NONE)
        else $error("event without a held sign");

    a_best_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> best_area_reg == '0 && best_sign_reg == SIGN_NONE)
        else $error("frame best not cleared at frame end");
`endif

endmodule

[rtl/core/speed_sign_confirm.sv]
// Speed sign confirmation. Feed detected objects one beat each on s_*; mark
// the last object of a frame with s_frame_end (an empty frame is one beat with
// code 0). Within a frame the sign with the strictly largest box area wins;
// at frame end a presence filter runs and exactly one result beat leaves on
// m_*, with a limit or end-of-limit event when the same sign has been held for
// a time strictly between confirm_min_ms and confirm_max_ms, and the held sign
// forgotten after an absence strictly between clear_min_ms and clear_max_ms.
// Throughput is one object per clock unless a frame end beat waits on a stalled
// result; the frame end beat passes the object register before the result
// register loads: the box area multiply sits in front of the object register,
// and the best-sign compare and the filter update sit between it and the
// result register. A stalled result stalls only frame end beats; other objects
// flow until one waits in the object register. Write cfg_* only while idle.
module speed_sign_confirm
    import ssc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    // detected objects
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_sign_code,
    input  logic [COORD_BITS-1:0] s_box_x1,
    input  logic [COORD_BITS-1:0] s_box_y1,
    input  logic [COORD_BITS-1:0] s_box_x2,
    input  logic [COORD_BITS-1:0] s_box_y2,
    input  logic [31:0]           s_now_ms,
    input  logic                  s_frame_end,
    // per-frame results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_limit_event,
    output logic [6:0]            m_limit_kmh,
    output logic                  m_remove_event,
    output logic                  m_sign_present,
    output logic [3:0]            m_held_sign
);

    cfg_t                    cfg_reg, cfg_next;
    logic                    a_valid;
    item_t                   a_item;
    logic [2*COORD_BITS-1:0] a_area;
    logic                    take;

    // Registers always writable; an idle block on change is up to the user.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CONFIRM_MIN: cfg_next.confirm_min = cfg_wdata;
                CFG_CONFIRM_MAX: cfg_next.confirm_max = cfg_wdata;
                CFG_CLEAR_MIN:   cfg_next.clear_min   = cfg_wdata;
                CFG_CLEAR_MAX:   cfg_next.clear_max   = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.confirm_min <= CONFIRM_MIN_RST;
            cfg_reg.confirm_max <= CONFIRM_MAX_RST;
            cfg_reg.clear_min   <= CLEAR_MIN_RST;
            cfg_reg.clear_max   <= CLEAR_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Stage 1: register the object with its box area.
    ssc_area_stage #(
        .COORD_BITS(COORD_BITS)
    ) u_area (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sign_code (s_sign_code),
        .s_box_x1    (s_box_x1),
        .s_box_y1    (s_box_y1),
        .s_box_x2    (s_box_x2),
        .s_box_y2    (s_box_y2),
        .s_now_ms    (s_now_ms),
        .s_frame_end (s_frame_end),
        .take        (take),
        .a_valid     (a_valid),
        .a_item      (a_item),
        .a_area      (a_area)
    );

    // Stage 2: track the frame's best sign, run the filter at frame end.
    ssc_presence #(
        .AREA_BITS(2*COORD_BITS)
    ) u_presence (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .a_valid        (a_valid),
        .a_item         (a_item),
        .a_area         (a_area),
        .cfg            (cfg_reg),
        .take           (take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_limit_event  (m_limit_event),
        .m_limit_kmh    (m_limit_kmh),
        .m_remove_event (m_remove_event),
        .m_sign_present (m_sign_present),
        .m_held_sign    (m_held_sign)
    );

endmodule

[dv/speed_sign_confirm_test.sv]
`timescale 1ns / 1ps

module speed_sign_confirm_test;
    import ssc_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int CYCLE_LIMIT = 400000;
    // Spare clocks after the last result beat before registers change.
    localparam int SETTLE      = 4;

    typedef struct {
        logic [3:0]            code;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
        logic [31:0]           now;
        logic                  frame_end;
    } detection_t;

    typedef struct {
        logic       limit_event;
        logic [6:0] limit_kmh;
        logic       remove_event;
        logic       sign_present;
        logic [3:0] held_sign;
    } frame_verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = CFG_CONFIRM_MIN;
    logic [15:0]           cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [3:0]            s_sign_code = SIGN_NONE;
    logic [COORD_BITS-1:0] s_box_x1 = '0;
    logic [COORD_BITS-1:0] s_box_y1 = '0;
    logic [COORD_BITS-1:0] s_box_x2 = '0;
    logic [COORD_BITS-1:0] s_box_y2 = '0;
    logic [31:0]           s_now_ms = '0;
    logic                  s_frame_end = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_limit_event;
    logic [6:0]            m_limit_kmh;
    logic                  m_remove_event;
    logic                  m_sign_present;
    logic [3:0]            m_held_sign;

    speed_sign_confirm #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sign_code   (s_sign_code),
        .s_box_x1      (s_box_x1),
        .s_box_y1      (s_box_y1),
        .s_box_x2      (s_box_x2),
        .s_box_y2      (s_box_y2),
        .s_now_ms      (s_now_ms),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_limit_event (m_limit_event),
        .m_limit_kmh   (m_limit_kmh),
        .m_remove_event(m_remove_event),
        .m_sign_present(m_sign_present),
        .m_held_sign   (m_held_sign)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Detections waiting to be offered, and verdicts waiting to come out.
    detection_t     detect_q[$];
    frame_verdict_t verdict_q[$];

    // Predictor copy of the thresholds and of the filter state.
    cfg_t        windows = '{CONFIRM_MIN_RST, CONFIRM_MAX_RST, CLEAR_MIN_RST, CLEAR_MAX_RST};
    logic [23:0] best_area = '0;
    logic [3:0]  best_code = SIGN_NONE;
    logic        present = 1'b0;
    logic [3:0]  held = SIGN_NONE;
    logic [31:0] seen_at = '0;
    logic [31:0] lost_at = '0;

    logic [31:0] clock_ms = '0;   // running frame timestamp of the stimulus
    logic        obj_taken = 1'b0;
    bit          calm = 1'b0;     // no idling on either side
    bit          hold_done = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          cycle_cnt = 0;

    function automatic logic [6:0] kmh_for_code(logic [3:0] code);
        if (code == 4'd2)
            return 7'd5;
        if (code >= 4'd3 && code <= 4'd14)
            return 7'((code - 4'd2) * 10);
        return 7'd0;
    endfunction

    // Fold one detection into the frame's best sign; on the frame's last
    // object run the presence filter and queue the verdict it produces.
    task automatic predict_detection(detection_t d);
        logic [3:0]     code;
        logic [23:0]    area;
        logic [31:0]    dt;
        logic [3:0]     s;
        frame_verdict_t v;
        code = (d.code == SIGN_INVALID) ? SIGN_NONE : d.code;
        if (code != SIGN_NONE) begin
            area = (d.x2 > d.x1 && d.y2 > d.y1) ? (d.x2 - d.x1) * (d.y2 - d.y1) : 24'd0;
            // strictly larger only: ties keep the earlier sign
            if (area > best_area) begin
                best_area = area;
                best_code = code;
            end
        end
        if (!d.frame_end)
            return;
        v = '{1'b0, 7'd0, 1'b0, 1'b0, SIGN_NONE};
        s = best_code;
        if (present && s == SIGN_NONE) begin
            lost_at = d.now;
            present = 1'b0;
        end else if (!present && s != SIGN_NONE) begin
            seen_at = d.now;
            held = s;
            present = 1'b1;
        end else if (present) begin
            if (s != held) begin
                seen_at = d.now;
                held = s;
            end else begin
                dt = d.now - seen_at;
                if (dt > windows.confirm_min && dt < windows.confirm_max) begin
                    if (s == SIGN_END) begin
                        v.remove_event = 1'b1;
                    end else begin
                        v.limit_event = 1'b1;
                        v.limit_kmh = kmh_for_code(s);
                    end
                end
            end
        end else begin
            dt = d.now - lost_at;
            if (dt > windows.clear_min && dt < windows.clear_max) begin
                held = SIGN_NONE;
                present = 1'b0;
            end
        end
        best_area = '0;
        best_code = SIGN_NONE;
        v.sign_present = present;
        v.held_sign = held;
        verdict_q.push_back(v);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Monitor: predict on every accepted detection, compare every result beat
    // against the oldest verdict still owed.
    always @(posedge aclk) begin
        detection_t     d;
        frame_verdict_t want;
        if (!aresetn) begin
            obj_taken <= 1'b0;
        end else begin
            obj_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                d.code = s_sign_code;
                d.x1 = s_box_x1;
                d.y1 = s_box_y1;
                d.x2 = s_box_x2;
                d.y2 = s_box_y2;
                d.now = s_now_ms;
                d.frame_end = s_frame_end;
                predict_detection(d);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    $error("result beat with no verdict waiting");
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("limit_event", want.limit_event, m_limit_event);
                    check_field("limit_kmh", want.limit_kmh, m_limit_kmh);
                    check_field("remove_event", want.remove_event, m_remove_event);
                    check_field("sign_present", want.sign_present, m_sign_present);
                    check_field("held_sign", want.held_sign, m_held_sign);
                end
            end
        end
    end

    // Driver: hold a beat until it is taken, then advance to the next queued
    // detection, dropping valid for a random burst now and then.
    always @(negedge aclk) begin
        detection_t d;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || obj_taken) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (detect_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                send_gap = $urandom_range(1, 15) - 1;
            end else if (detect_q.size() > 0) begin
                d = detect_q.pop_front();
                s_sign_code <= d.code;
                s_box_x1 <= d.x1;
                s_box_y1 <= d.y1;
                s_box_x2 <= d.x2;
                s_box_y2 <= d.y2;
                s_now_ms <= d.now;
                s_frame_end <= d.frame_end;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random ready bursts, plus one long hold-off once traffic is
    // flowing so the result register backs up and the input stalls.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 600;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            m_ready <= 1'b0;
            recv_gap--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            recv_gap = $urandom_range(1, 15) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic add_detection(logic [3:0] code, logic [COORD_BITS-1:0] x1,
                                 logic [COORD_BITS-1:0] y1, logic [COORD_BITS-1:0] x2,
                                 logic [COORD_BITS-1:0] y2, logic [31:0] now,
                                 logic frame_end);
        detection_t d;
        d = '{code, x1, y1, x2, y2, now, frame_end};
        detect_q.push_back(d);
    endtask

    // Single full-size sign as a whole frame.
    task automatic add_frame(logic [3:0] code, logic [31:0] now);
        add_detection(code, '0, '0, '1, '1, now, 1'b1);
    endtask

    // Scenes: one sign stays in view over a run of frames (or none does),
    // surrounded by random clutter; timestamps step forward by up to step_hi
    // and occasionally jump anywhere.
    task automatic add_scenes(int n, int unsigned step_hi);
        int         added;
        int         nobj;
        int         lead;
        logic [3:0] scene;
        logic [3:0] code;
        added = 0;
        scene = SIGN_NONE;
        while (added < n) begin
            if ($urandom_range(0, 7) == 0)
                scene = ($urandom_range(0, 2) == 0) ? SIGN_NONE : 4'($urandom_range(1, 15));
            if ($urandom_range(0, 39) == 0)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, step_hi);
            nobj = (scene == SIGN_NONE) ? $urandom_range(1, 2) : $urandom_range(1, 4);
            lead = $urandom_range(0, nobj - 1);
            for (int k = 0; k < nobj; k++) begin
                if (k == lead && scene != SIGN_NONE) begin
                    add_detection(scene,
                                  COORD_BITS'($urandom_range(0, 200)),
                                  COORD_BITS'($urandom_range(0, 200)),
                                  COORD_BITS'($urandom_range(3000, 4095)),
                                  COORD_BITS'($urandom_range(3000, 4095)),
                                  clock_ms, k == nobj - 1);
                end else begin
                    if (scene == SIGN_NONE && $urandom_range(0, 3) != 0)
                        code = $urandom_range(0, 1) ? SIGN_NONE : SIGN_INVALID;
                    else
                        code = 4'($urandom_range(0, 15));
                    // only the frame's last object carries a timestamp that matters
                    add_detection(code,
                                  COORD_BITS'($urandom_range(0, 4095)),
                                  COORD_BITS'($urandom_range(0, 4095)),
                                  COORD_BITS'($urandom_range(0, 4095)),
                                  COORD_BITS'($urandom_range(0, 4095)),
                                  (k == nobj - 1) ? clock_ms : $urandom(), k == nobj - 1);
                end
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (detect_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_CONFIRM_MIN: windows.confirm_min = value;
            CFG_CONFIRM_MAX: windows.confirm_max = value;
            CFG_CLEAR_MIN:   windows.clear_min = value;
            default:         windows.clear_max = value;
        endcase
    endtask

    // Reprogram all four windows once the block has gone idle.
    task automatic set_windows(logic [15:0] cmin, logic [15:0] cmax,
                               logic [15:0] lmin, logic [15:0] lmax);
        wait_drained();
        write_reg(CFG_CONFIRM_MIN, cmin);
        write_reg(CFG_CONFIRM_MAX, cmax);
        write_reg(CFG_CLEAR_MIN, lmin);
        write_reg(CFG_CLEAR_MAX, lmax);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        // Directed frames under the reset windows (200/10000, 1000/10000).
        add_frame(SIGN_NONE, 32'd0);            // empty frame straight out of reset
        add_frame(4'd7, 32'd100);               // new sign, timer starts
        add_frame(4'd7, 32'd300);               // exactly confirm_min: no event
        add_frame(4'd7, 32'd301);               // just past it: limit 50
        add_frame(4'd7, 32'd10099);             // just under confirm_max: event
        add_frame(4'd7, 32'd10100);             // exactly confirm_max: no event
        // Ties keep the earlier sign; zero-width box, code 15 and code 0
        // never win despite their boxes.
        add_detection(4'd14, 12'd10, 12'd10, 12'd20, 12'd20, $urandom(), 1'b0);
        add_detection(4'd2, 12'd0, 12'd0, 12'd10, 12'd10, $urandom(), 1'b0);
        add_detection(4'd3, 12'd5, 12'd5, 12'd5, 12'd100, $urandom(), 1'b0);
        add_detection(SIGN_INVALID, '0, '0, '1, '1, $urandom(), 1'b0);
        add_detection(SIGN_NONE, '0, '0, '1, '1, 32'd10200, 1'b1);
        add_frame(4'd14, 32'd10401);            // limit 120
        // Inverted boxes only: the sign is lost.
        add_detection(SIGN_END, 12'd100, 12'd100, 12'd50, 12'd200, $urandom(), 1'b0);
        add_detection(4'd9, 12'd0, 12'd50, 12'd4095, 12'd40, 32'd10500, 1'b1);
        add_frame(SIGN_NONE, 32'd11500);        // exactly clear_min: still held
        add_frame(SIGN_NONE, 32'd11501);        // past it: forgotten
        add_frame(SIGN_END, 32'd12000);
        add_frame(SIGN_END, 32'd12201);         // end-of-limit event
        add_detection(4'd2, '1, '1, '1, '1, $urandom(), 1'b0);
        add_detection(4'd8, 12'd4094, 12'd4094, 12'd4095, 12'd4095, 32'd12300, 1'b1);
        // Time differences wrap through 2^32.
        add_frame(SIGN_NONE, 32'hFFFF_FF00);
        add_frame(SIGN_NONE, 32'h0000_0300);
        add_frame(4'd5, 32'hFFFF_FFF0);
        add_frame(4'd5, 32'h0000_0100);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        clock_ms = 32'd20000;
        add_scenes(380, 600);

        // Every window empty: nothing confirms, nothing clears.
        set_windows(16'd0, 16'd0, 16'd0, 16'd0);
        add_scenes(380, 20);

        set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_scenes(380, 20000);

        // Widest windows, with steps that land on both sides of the top.
        set_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        add_scenes(380, 20000);

        // Tight windows, full rate on both sides to the end.
        set_windows(16'd3, 16'd40, 16'd2, 16'd30);
        calm = 1'b1;
        add_scenes(380, 20);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/ssc_pkg.sv
rtl/core/ssc_area_stage.sv
rtl/core/ssc_presence.sv
rtl/core/speed_sign_confirm.sv
dv/speed_sign_confirm_test.sv
